[rtl/tdq_pkg.sv]
`timescale 1ns / 1ps
// Package for the TPDF dither quantizer: payload structs, controller states,
// command struct and the dither generator step function.
// Depends on nothing; every other file in rtl uses it.

package tdq_pkg;

  // Linear congruential generator constants.
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  // Width of the exact dithered value with 24 fraction bits.
  localparam int unsigned VW = 42;

  // Q1.23 sample times 2 * 32767 gives units of 2^-24.
  localparam logic signed [40:0] SAMPLE_SCALE = 41'sd65534;

  // Saturation bounds of the dithered value: 32767 * 2^24 and -32768 * 2^24.
  localparam logic signed [VW-1:0] V_HI = 42'sh007FFF000000;
  localparam logic signed [VW-1:0] V_LO = 42'sh38000000000;

  // Half an output LSB, for rounding to nearest with ties upward.
  localparam logic signed [VW-1:0] ROUND_HALF = 42'sd8388608;

  typedef struct packed {
    logic signed [23:0] sample_in;
    logic               end_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pcm_out;
    logic               clipped;
    logic               end_of_block_out;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP2,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // take the input item and step the generator once
    logic step2;   // second generator step and partial sum
    logic finish;  // round, saturate and load the output register
  } cmd_t;

  function automatic logic [31:0] lcg_next(input logic [31:0] x);
    lcg_next = x * LCG_MUL + LCG_ADD;
  endfunction

endpackage

[rtl/tdq_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the TPDF dither quantizer: generator state, sample scaling,
// dither sum, rounding, saturation and the output register.
// Depends on tdq_pkg.

module tdq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  tdq_pkg::cmd_t     cmd,
  input  logic              cfg_write_en,
  input  logic [31:0]       cfg_write_data,
  input  tdq_pkg::in_item_t in_data,
  output tdq_pkg::out_item_t out_data
);

  logic [31:0]                     dither_state;
  logic [23:0]                     u1;
  logic [23:0]                     u2;
  logic signed [40:0]              prod;
  logic signed [tdq_pkg::VW-1:0]   acc;
  logic                            eob;

  logic [31:0]                     lcg_q;
  logic signed [40:0]              prod_next;
  logic signed [tdq_pkg::VW-1:0]   acc_next;
  logic signed [tdq_pkg::VW-1:0]   v;
  logic signed [tdq_pkg::VW-1:0]   v_round;
  tdq_pkg::out_item_t              out_next;

  // One generator step, shared by both steps of an item.
  assign lcg_q     = tdq_pkg::lcg_next(dither_state);
  assign prod_next = 41'(in_data.sample_in) * tdq_pkg::SAMPLE_SCALE;
  assign acc_next  = tdq_pkg::VW'(prod) + $signed({18'd0, u1});

  always_comb begin
    v       = acc - $signed({18'd0, u2});
    v_round = v + tdq_pkg::ROUND_HALF;
    out_next.end_of_block_out = eob;
    if (v > tdq_pkg::V_HI) begin
      out_next.pcm_out = 16'sh7FFF;
      out_next.clipped = 1'b1;
    end else if (v < tdq_pkg::V_LO) begin
      out_next.pcm_out = 16'sh8000;
      out_next.clipped = 1'b1;
    end else begin
      out_next.pcm_out = v_round[39:24];
      out_next.clipped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dither_state <= '0;
    end else if (cfg_write_en) begin
      dither_state <= cfg_write_data;
    end else if (cmd.start || cmd.step2) begin
      dither_state <= lcg_q;
    end
    if (cmd.start) begin
      u1   <= lcg_q[31:8];
      prod <= prod_next;
      eob  <= in_data.end_of_block;
    end
    if (cmd.step2) begin
      u2  <= lcg_q[31:8];
      acc <= acc_next;
    end
    if (cmd.finish) begin
      out_data <= out_next;
    end
  end

endmodule

[rtl/tdq_controller.sv]
`timescale 1ns / 1ps
// Controller of the TPDF dither quantizer: sequences the two generator steps
// and the final stage, and owns both handshakes.
// Depends on tdq_pkg.

module tdq_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output tdq_pkg::cmd_t cmd
);

  tdq_pkg::state_t state;
  tdq_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      tdq_pkg::S_IDLE: begin
        if (in_valid) state_next = tdq_pkg::S_STEP2;
      end
      tdq_pkg::S_STEP2: begin
        state_next = tdq_pkg::S_FINISH;
      end
      tdq_pkg::S_FINISH: begin
        if (out_free) state_next = in_valid ? tdq_pkg::S_STEP2 : tdq_pkg::S_IDLE;
      end
      default: begin
        state_next = tdq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.step2  = 1'b0;
    cmd.finish = 1'b0;
    unique case (state)
      tdq_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      tdq_pkg::S_STEP2: begin
        cmd.step2 = 1'b1;
      end
      tdq_pkg::S_FINISH: begin
        // The next item overlaps the output stage of this one.
        in_ready   = out_free;
        cmd.finish = out_free;
        cmd.start  = out_free && in_valid;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tdq_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/tpdf_dither_quantizer.sv]
`timescale 1ns / 1ps
// Top level of the TPDF dither quantizer: controller plus datapath.
// Depends on tdq_pkg, tdq_controller and tdq_datapath.

// Converts signed Q1.23 audio samples to 16-bit PCM with triangular dither.
// Each input transaction yields exactly one output transaction, in order.
// A 32-bit linear congruential generator is stepped twice per sample; the
// top 24 bits of the two new states are subtracted to form dither of plus or
// minus one LSB, which is added to the sample scaled by 32767. The sum is
// rounded to nearest with ties upward and saturated to the 16-bit range;
// clipped flags a saturated result and end_of_block_out copies the marker.
// Writing cfg_write_data with cfg_write_en loads the generator state at once;
// write it only while no transaction is in flight. The generator state resets
// to zero. The edge that accepts a sample takes the first generator step;
// the second follows in S_STEP2, and S_FINISH rounds, saturates and loads
// the output register, making the result valid. No new sample is taken
// during the second step, as the two dependent generator steps share one
// 32-bit multiply-add; the rounding stage of one sample overlaps the first
// generator step of the next. A stalled output holds further input back.

module tpdf_dither_quantizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tdq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tdq_pkg::out_item_t out_data,
  input  logic               cfg_write_en,
  input  logic [31:0]        cfg_write_data
);

  tdq_pkg::cmd_t cmd;

  tdq_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tdq_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_data        (in_data),
    .out_data       (out_data)
  );

  // After a sample is taken the block is busy with its second generator step.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted during second generator step");

  // A rising output valid traces back to the edge that accepted its sample,
  // through the S_STEP2 and S_FINISH states.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("result appeared without a matching accepted sample");

endmodule

[dv/tpdf_dither_quantizer_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for tpdf_dither_quantizer: directed and random
// samples through valid/ready channels, checked against a built-in predictor.
// Depends on tdq_pkg for the payload structs and on the RTL top level.

module tpdf_dither_quantizer_test;

  import tdq_pkg::*;

  localparam int SETTLE_CYCLES = 8;      // quiet cycles before a seed write and at the end
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
  localparam int STALL_CYCLES = 150;     // long output hold-off
  localparam int REPORT_LINES = 60;      // mismatches printed before going quiet
  localparam int PHASE_ITEMS = 356;
  localparam int SEED_INTERVAL = 128;    // items between reseeds in random phases

  localparam longint LCG_FACTOR = 64'd1664525;
  localparam longint LCG_OFFSET = 64'd1013904223;
  localparam longint SAMPLE_GAIN = 64'sd65534;  // 2 * 32767, result in 2^-24 units
  localparam longint PCM_TOP = 64'sd32767;
  localparam longint PCM_BOTTOM = -64'sd32768;
  localparam int FRAC_BITS = 24;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic        cfg_write_en = 1'b0;
  logic [31:0] cfg_write_data = '0;

  // Predictor copy of the generator state and the PCM results still owed.
  logic [31:0] dither_model = '0;
  out_item_t   pcm_expected_q[$];

  int error_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold_left = 0;
  int quiet_cycles = 0;

  tpdf_dither_quantizer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // One step of the 32-bit linear congruential generator, modulo 2^32.
  function automatic logic [31:0] lcg_advance(input logic [31:0] x);
    longint unsigned product;
    product = longint'(x) * LCG_FACTOR + LCG_OFFSET;
    return product[31:0];
  endfunction

  // Advances the generator twice and forms the dithered, rounded and
  // saturated PCM sample. The sum is kept exact in units of 2^-24.
  function automatic out_item_t quantize_with_dither(input in_item_t item);
    logic [31:0] first_state;
    logic [31:0] second_state;
    longint      dithered;
    longint      rounded;
    out_item_t   res;
    first_state = lcg_advance(dither_model);
    second_state = lcg_advance(first_state);
    dither_model = second_state;
    dithered = longint'($signed(item.sample_in)) * SAMPLE_GAIN
             + longint'(first_state[31:8]) - longint'(second_state[31:8]);
    res.end_of_block_out = item.end_of_block;
    if (dithered > (PCM_TOP <<< FRAC_BITS)) begin
      res.pcm_out = 16'(PCM_TOP);
      res.clipped = 1'b1;
    end else if (dithered < (PCM_BOTTOM <<< FRAC_BITS)) begin
      res.pcm_out = 16'(PCM_BOTTOM);
      res.clipped = 1'b1;
    end else begin
      // Arithmetic shift floors, so adding half an LSB rounds ties upward.
      rounded = (dithered + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (rounded > PCM_TOP) rounded = PCM_TOP;
      if (rounded < PCM_BOTTOM) rounded = PCM_BOTTOM;
      res.pcm_out = 16'(rounded);
      res.clipped = 1'b0;
    end
    return res;
  endfunction

  // The printout is capped so a broken build cannot flood the log, but every
  // mismatch is counted.
  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < REPORT_LINES) begin
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    error_count++;
  endtask

  // Output side: compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pcm_expected_q.size() == 0) begin
        report_mismatch("unexpected result, pcm_out", int'($signed(out_data.pcm_out)), 0);
      end else begin
        want = pcm_expected_q.pop_front();
        if (out_data.pcm_out !== want.pcm_out) begin
          report_mismatch("pcm_out", int'($signed(out_data.pcm_out)),
                          int'($signed(want.pcm_out)));
        end
        if (out_data.clipped !== want.clipped) begin
          report_mismatch("clipped", int'(out_data.clipped), int'(want.clipped));
        end
        if (out_data.end_of_block_out !== want.end_of_block_out) begin
          report_mismatch("end_of_block_out", int'(out_data.end_of_block_out),
                          int'(want.end_of_block_out));
        end
      end
    end
  end

  // Receiver: a requested hold-off takes priority over random idling.
  always @(negedge clk) begin
    if (recv_hold_left > 0) begin
      out_ready <= 1'b0;
      recv_hold_left = recv_hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tpdf_dither_quantizer_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one sample, called at a falling edge. Returns at the falling edge
  // after acceptance with valid still high, so back-to-back items never
  // drop valid in between unless random idling is on.
  task automatic send_sample(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data <= in_item_t'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pcm_expected_q.push_back(quantize_with_dither(item));
    @(negedge clk);
  endtask

  // Stops offering and waits until every owed result has been accepted.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pcm_expected_q.size() != 0) @(negedge clk);
  endtask

  // Loads the generator state; only done with nothing in flight.
  task automatic write_seed(input logic [31:0] seed);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= seed;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    dither_model = seed;
    @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    @(negedge clk);
  endtask

  // Random samples, weighted toward the two ends of full scale where the
  // clipping and saturation logic lives, plus small values near zero.
  function automatic in_item_t random_sample();
    in_item_t item;
    item.end_of_block = ($urandom_range(3) == 0);
    case ($urandom_range(9))
      5: item.sample_in = 24'sh7FFFFF - 24'($urandom_range(300));
      6: item.sample_in = 24'sh800000 + 24'($urandom_range(300));
      7: item.sample_in = 24'($signed($urandom_range(1024)) - 512);
      default: item.sample_in = 24'($urandom);
    endcase
    return item;
  endfunction

  // Field extremes straight after reset (generator state zero), then again
  // from the all-ones and zero seeds. Positive full scale is repeated since
  // only about half the dither values push it past the top bound; negative
  // full scale must never clip.
  task automatic test_edge_samples();
    int unsigned edge_samples[12] = '{
      24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
      24'h800000, 24'h800000, 24'h400000, 24'hC00000, 24'h000100, 24'hFFFF00
    };
    in_item_t item;
    for (int i = 0; i < 12; i++) begin
      item.sample_in = edge_samples[i][23:0];
      item.end_of_block = i[0];
      send_sample(item);
    end
    write_seed(32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) begin
      item.sample_in = (i < 4) ? 24'sh7FFFFF : 24'sh800000;
      item.end_of_block = (i == 5);
      send_sample(item);
    end
    write_seed(32'h0000_0000);
    for (int i = 0; i < 4; i++) begin
      item.sample_in = i[0] ? 24'sh7FFFFF : 24'sh800000;
      item.end_of_block = (i == 3);
      send_sample(item);
    end
    wait_for_drain();
  endtask

  // A random traffic phase under one idling profile, reseeded periodically.
  task automatic test_random_traffic(input int count, input int send_pct,
                                     input int recv_pct);
    write_seed($urandom);
    set_idling(send_pct, recv_pct);
    for (int i = 0; i < count; i++) begin
      if (i > 0 && i % SEED_INTERVAL == 0) write_seed($urandom);
      send_sample(random_sample());
    end
    wait_for_drain();
  endtask

  // The receiver stops for a long stretch while the sender keeps offering,
  // so the block fills and holds its input back; then the sender pauses
  // until every owed result is out.
  task automatic test_output_stall();
    set_idling(0, 0);
    write_seed(32'h1234_5678);
    @(posedge clk);
    recv_hold_left = STALL_CYCLES;
    @(negedge clk);
    for (int i = 0; i < 30; i++) send_sample(random_sample());
    wait_for_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_edge_samples();
    test_output_stall();
    test_random_traffic(PHASE_ITEMS, 17, 75);
    test_random_traffic(PHASE_ITEMS, 75, 17);
    test_random_traffic(PHASE_ITEMS, 0, 0);
    test_output_stall();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && pcm_expected_q.size() == 0) begin
      $display("tpdf_dither_quantizer_test: PASS");
    end else begin
      $display("tpdf_dither_quantizer_test: FAIL");
    end
    $finish;
  end

endmodule
